### design/dipdb_pkg.sv
// Package for the DIP dead-block / stream-bypass replacement unit.
// Holds sizes, codes, the set-row layout and shared helper functions.
// No dependencies.
package dipdb_pkg;

   // Cache geometry and policy sizes
   localparam int NUM_SETS      = 2048;
   localparam int NUM_WAYS      = 16;
   localparam int LEADER_SETS   = 32;
   localparam int SELECTOR_BITS = 10;
   localparam int HISTORY_DEPTH = 4;

   localparam int SET_BITS    = $clog2(NUM_SETS);
   localparam int WAY_BITS    = $clog2(NUM_WAYS);
   localparam int RANK_BITS   = WAY_BITS;
   localparam int REUSE_BITS  = 2;
   localparam int PTR_BITS    = $clog2(HISTORY_DEPTH);
   localparam int ADDR_BITS   = 48;

   // leaves of the victim compare tree, ways rounded up to a power of two
   localparam int TREE_LEAVES = 1 << WAY_BITS;

   // Fixed field widths of the streams
   localparam int SET_IDX_BITS = 11;
   localparam int WAY_IDX_BITS = 4;
   localparam int THRESH_BITS  = 3;
   localparam int MASK_BITS    = 5;
   localparam int ACC_BITS     = 5;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 5;
   localparam int REQ_DATA_BITS = 64;
   localparam int RSP_DATA_BITS = 8;

   localparam int LEADER_STRIDE = (NUM_SETS / LEADER_SETS) > 0 ? (NUM_SETS / LEADER_SETS) : 1;
   localparam int LIP_LEADERS   = LEADER_SETS / 2;
   localparam int PSEL_HALF     = 1 << (SELECTOR_BITS - 1);
   localparam int PSEL_MAX      = (1 << SELECTOR_BITS) - 1;
   localparam int REUSE_MAX     = 3;

   localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(3);
   localparam logic [MASK_BITS-1:0]   MASK_RESET   = MASK_BITS'(31);

   typedef enum logic [1:0] {
      SIGN_ZERO = 2'd0,
      SIGN_POS  = 2'd1,
      SIGN_NEG  = 2'd2
   } sign_type;

   typedef enum logic {
      OP_QUERY  = 1'b0,
      OP_UPDATE = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_STREAM_THRESHOLD = 2'd0,
      CSR_BIP_MASK         = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // One row of metadata per set
   typedef struct packed {
      logic [NUM_WAYS-1:0][RANK_BITS-1:0]  rank;
      logic [NUM_WAYS-1:0][REUSE_BITS-1:0] reuse;
      logic [ADDR_BITS-1:0]                prev_addr;
      sign_type [HISTORY_DEPTH-1:0]        signs;
      logic [PTR_BITS-1:0]                 ptr;
      logic                                streaming;
   } row_type;

   localparam int ROW_BITS = $bits(row_type);

   typedef struct packed {
      op_type                op;
      logic [SET_BITS-1:0]   set;
      logic [WAY_BITS-1:0]   way;
      logic [ADDR_BITS-1:0]  addr;
      logic                  hit;
   } item_type;

   typedef struct packed {
      logic [WAY_IDX_BITS-1:0] victim_way;
      logic                    set_streaming;
      logic                    fill_bypassed;
   } result_type;

   // Global policy context handed to the row update logic
   typedef struct packed {
      logic [SELECTOR_BITS-1:0] psel;
      logic [ACC_BITS-1:0]      acc_count;
      logic [THRESH_BITS-1:0]   threshold;
      logic [MASK_BITS-1:0]     bip_mask;
   } policy_type;

   function automatic row_type row_reset();
      row_type r;
      r = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         r.rank[w]  = RANK_BITS'(NUM_WAYS - 1);
         r.reuse[w] = REUSE_BITS'(1);
      end
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
         r.signs[k] = SIGN_ZERO;
      end
      return r;
   endfunction

   function automatic logic [SET_BITS-1:0] set_of(input logic [SET_IDX_BITS-1:0] s);
      return SET_BITS'(s % NUM_SETS);
   endfunction

   function automatic logic [WAY_BITS-1:0] way_of(input logic [WAY_IDX_BITS-1:0] w);
      return WAY_BITS'(w % NUM_WAYS);
   endfunction

endpackage

### design/dip_deadblock_stream_bypass_replacement_unit.sv
// Top level of the DIP dead-block / stream-bypass replacement unit.
// An accepted request beat is registered into the item register and the lookup state; its result
// is then registered into the response register when the lookup advances. A new request beat is
// taken only in idle, after the read-modify-write of the set row in the single metadata RAM; a
// response still held stalls the next write-back. Reset: synchronous; afterwards a clearing pass
// writes each of the NUM_SETS (2048) set rows to its reset value while req_tready stays low. Depends on dipdb_pkg.
module dip_deadblock_stream_bypass_replacement_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [10:0] set_index, [14:11] way_index, [62:15] phys_addr, [63] was_hit
   input  logic [dipdb_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // [0] operation
   input  logic                                  req_tuser,
   // response stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [3:0] victim_way, [4] set_streaming, [5] fill_bypassed, [7:6] zero
   output logic [dipdb_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dipdb_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [dipdb_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import dipdb_pkg::*;

   state_type                state_ff, state_in;
   logic [SET_BITS-1:0]      clr_ff, clr_in;
   item_type                 item_ff, item_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   result_type               rsp_data_ff, rsp_data_in;
   logic [SELECTOR_BITS-1:0] psel_ff, psel_in;
   logic [ACC_BITS-1:0]      acc_ff, acc_in;
   logic [THRESH_BITS-1:0]   thresh_ff, thresh_in;
   logic [MASK_BITS-1:0]     mask_ff, mask_in;

   logic                     accept;
   logic                     advance;
   logic                     mem_wr_en;
   logic [SET_BITS-1:0]      mem_wr_addr;
   row_type                  mem_wr_data;
   logic                     mem_rd_en;
   logic [SET_BITS-1:0]      mem_rd_addr;
   row_type                  mem_rd_data;
   row_type                  row_new;
   result_type               result;
   logic [SELECTOR_BITS-1:0] psel_new;
   policy_type               policy;
   logic [ACC_BITS-1:0]      acc_next;

   // metadata store, one row per set
   dipdb_ram #(
      .WIDTH(ROW_BITS),
      .DEPTH(NUM_SETS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // update logic sees the incremented access count
   assign acc_next = acc_ff + 1'b1;
   always_comb begin
      policy.psel      = psel_ff;
      policy.acc_count = acc_next;
      policy.threshold = thresh_ff;
      policy.bip_mask  = mask_ff;
   end

   dipdb_row_update u_row_update (
      .item     (item_ff),
      .row_in   (mem_rd_data),
      .policy   (policy),
      .row_out  (row_new),
      .result   (result),
      .psel_out (psel_new)
   );

   // handshake terms
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign advance    = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;

   // sequencer: clear pass, idle, lookup/write-back
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      item_in      = item_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      psel_in      = psel_ff;
      acc_in       = acc_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = item_ff.set;
      mem_wr_data  = row_new;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = set_of(req_tdata[10:0]);

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = row_reset();
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == SET_BITS'(NUM_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               mem_rd_en    = 1'b1;
               item_in.op   = op_type'(req_tuser);
               item_in.set  = set_of(req_tdata[10:0]);
               item_in.way  = way_of(req_tdata[14:11]);
               item_in.addr = req_tdata[62:15];
               item_in.hit  = req_tdata[63];
               state_in     = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (advance) begin
               rsp_data_in  = result;
               rsp_valid_in = 1'b1;
               if (item_ff.op == OP_UPDATE) begin
                  mem_wr_en = 1'b1;
                  psel_in   = psel_new;
                  acc_in    = acc_next;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration registers
   always_comb begin
      thresh_in = thresh_ff;
      mask_in   = mask_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_STREAM_THRESHOLD) thresh_in = csr_data[THRESH_BITS-1:0];
         if (csr_index == CSR_BIP_MASK) mask_in = csr_data[MASK_BITS-1:0];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         psel_ff      <= SELECTOR_BITS'(PSEL_HALF);
         acc_ff       <= '0;
         thresh_ff    <= THRESH_RESET;
         mask_ff      <= MASK_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         psel_ff      <= psel_in;
         acc_ff       <= acc_in;
         thresh_ff    <= thresh_in;
         mask_ff      <= mask_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff.fill_bypassed, rsp_data_ff.set_streaming,
                        rsp_data_ff.victim_way};

   // an accepted beat always moves the sequencer into lookup
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_LOOKUP))
      else $error("accepted request did not start a lookup");

   // the row read never coincides with a write-back or clear write
   assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("metadata read overlaps a write");

   // dueling counter only moves on an update write-back
   assert property (@(posedge clock) disable iff (reset)
      !(advance && (item_ff.op == OP_UPDATE)) |=> $stable(psel_ff))
      else $error("policy selector changed without an update");

endmodule

### design/dipdb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dipdb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/dipdb_row_update.sv
// Read-modify-write logic for one set row: victim search, stream detector,
// LRU aging, reuse counters and DIP set dueling. Depends on dipdb_pkg.
module dipdb_row_update (
   input  dipdb_pkg::item_type                    item,
   input  dipdb_pkg::row_type                     row_in,
   input  dipdb_pkg::policy_type                  policy,
   output dipdb_pkg::row_type                     row_out,
   output dipdb_pkg::result_type                  result,
   output logic [dipdb_pkg::SELECTOR_BITS-1:0]    psel_out
);
   import dipdb_pkg::*;

   // Victim: largest rank, highest way on ties; a log-depth compare tree
   function automatic logic [WAY_BITS-1:0] victim_of(
      input logic [NUM_WAYS-1:0][RANK_BITS-1:0] r
   );
      logic [TREE_LEAVES-1:0][RANK_BITS-1:0] rk;
      logic [TREE_LEAVES-1:0][WAY_BITS-1:0]  ix;
      logic [TREE_LEAVES-1:0]                vl;
      logic                                  take_b;
      for (int i = 0; i < TREE_LEAVES; i++) begin
         rk[i] = (i < NUM_WAYS) ? r[i] : '0;
         ix[i] = WAY_BITS'(i);
         vl[i] = (i < NUM_WAYS);
      end
      for (int lvl = 0; lvl < WAY_BITS; lvl++) begin
         for (int i = 0; i < (TREE_LEAVES >> (lvl + 1)); i++) begin
            take_b = vl[2*i+1] && (!vl[2*i] || (rk[2*i+1] >= rk[2*i]));
            rk[i]  = take_b ? rk[2*i+1] : rk[2*i];
            ix[i]  = take_b ? ix[2*i+1] : ix[2*i];
            vl[i]  = vl[2*i] || vl[2*i+1];
         end
      end
      return ix[0];
   endfunction

   logic [RANK_BITS-1:0] limit;
   logic [RANK_BITS-1:0] ins;
   logic                 leader;
   logic                 bip_leader;
   logic                 use_bip;
   sign_type             code;
   int                   pos_cnt;
   int                   neg_cnt;
   int                   nz_cnt;
   logic                 stream;

   always_comb begin
      row_out    = row_in;
      result     = '0;
      psel_out   = policy.psel;
      limit      = '0;
      ins        = '0;
      code       = SIGN_ZERO;
      pos_cnt    = 0;
      neg_cnt    = 0;
      nz_cnt     = 0;
      stream     = row_in.streaming;
      leader     = (item.set % LEADER_STRIDE) == 0;
      bip_leader = leader && ((item.set / LEADER_STRIDE) >= LIP_LEADERS);
      use_bip    = leader ? bip_leader : (policy.psel < SELECTOR_BITS'(PSEL_HALF));

      if (item.op == OP_QUERY) begin
         result.victim_way    = WAY_IDX_BITS'(victim_of(row_in.rank));
         result.set_streaming = row_in.streaming;
      end else begin
         // stream detector
         if (row_in.prev_addr != '0) begin
            if (item.addr > row_in.prev_addr) begin
               code = SIGN_POS;
            end else if (item.addr < row_in.prev_addr) begin
               code = SIGN_NEG;
            end
            row_out.signs[row_in.ptr] = code;
            row_out.ptr = (row_in.ptr == PTR_BITS'(HISTORY_DEPTH - 1)) ? '0 :
                          row_in.ptr + 1'b1;
         end
         row_out.prev_addr = item.addr;
         for (int k = 0; k < HISTORY_DEPTH; k++) begin
            if (row_out.signs[k] == SIGN_POS) pos_cnt++;
            else if (row_out.signs[k] == SIGN_NEG) neg_cnt++;
            if (row_out.signs[k] != SIGN_ZERO) nz_cnt++;
         end
         stream = (nz_cnt >= int'(policy.threshold)) &&
                  ((pos_cnt >= int'(policy.threshold)) || (neg_cnt >= int'(policy.threshold)));
         row_out.streaming    = stream;
         result.set_streaming = stream;

         priority if (!item.hit && stream) begin
            // streaming miss: park at LRU and bypass
            row_out.rank[item.way] = RANK_BITS'(NUM_WAYS - 1);
            result.fill_bypassed   = 1'b1;
         end else if (item.hit) begin
            // hit: promote to MRU
            limit = row_in.rank[item.way];
            for (int w = 0; w < NUM_WAYS; w++) begin
               if (row_in.rank[w] < limit) row_out.rank[w] = row_in.rank[w] + 1'b1;
            end
            row_out.rank[item.way] = '0;
            if (row_in.reuse[item.way] < REUSE_BITS'(REUSE_MAX)) begin
               row_out.reuse[item.way] = row_in.reuse[item.way] + 1'b1;
            end
         end else begin
            // fill: insertion position from reuse and dueling
            ins = (row_in.reuse[item.way] >= REUSE_BITS'(2)) ? '0 :
                  RANK_BITS'(NUM_WAYS - 1);
            if (use_bip) begin
               ins = ((policy.acc_count & policy.bip_mask) == '0) ? '0 :
                     RANK_BITS'(NUM_WAYS - 1);
            end
            for (int w = 0; w < NUM_WAYS; w++) begin
               if (row_in.rank[w] < ins) row_out.rank[w] = row_in.rank[w] + 1'b1;
            end
            row_out.rank[item.way]  = ins;
            row_out.reuse[item.way] = (ins == RANK_BITS'(NUM_WAYS - 1)) ?
                                      REUSE_BITS'(0) : REUSE_BITS'(1);
            if (leader) begin
               if (!bip_leader) begin
                  if (policy.psel < SELECTOR_BITS'(PSEL_MAX)) psel_out = policy.psel + 1'b1;
               end else begin
                  if (policy.psel != '0) psel_out = policy.psel - 1'b1;
               end
            end
         end
      end
   end

endmodule
